@@ design/gnt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gnt_pkg: shared types and constants for the gradient noise turbulence block
// Request modes, table selects, sequencer states, queue entry layout and an arithmetic helper.
// ----------------------------------------------------------------------------
package gnt_pkg;

   localparam int TABLE_ENTRIES_DEF = 256;
   localparam int MAX_OCTAVES_DEF   = 8;

   typedef enum logic [1:0] {
      MODE_LOAD_GRAD = 2'd0,
      MODE_LOAD_PERM = 2'd1,
      MODE_NOISE     = 2'd2,
      MODE_NONE      = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      SEL_X    = 2'd0,
      SEL_Y    = 2'd1,
      SEL_Z    = 2'd2,
      SEL_NONE = 2'd3
   } sel_type;

   // Sequencer states of the back end.
   typedef enum logic [3:0] {
      ST_IDLE, ST_PERM, ST_GADDR, ST_GRAD, ST_FADE1, ST_FADE2, ST_DOT, ST_SUM,
      ST_BX, ST_BY, ST_BZ, ST_ACC, ST_DONE
   } bst_type;

   // Classified request passed from front to back.
   typedef struct packed {
      mode_type    mode;
      sel_type     sel;
      logic [7:0]  index;
      logic [15:0] gx;
      logic [15:0] gy;
      logic [15:0] gz;
      logic [7:0]  perm;
      logic [31:0] px;
      logic [31:0] py;
      logic [31:0] pz;
      logic [4:0]  octaves;
   } job_type;

   // Floor division by 2^16 of a signed value.
   function automatic logic signed [63:0] fshr16(input logic signed [63:0] v);
      fshr16 = v >>> 16;
   endfunction

endpackage : gnt_pkg
`default_nettype wire

@@ design/gradient_noise_turbulence.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gradient_noise_turbulence: 3D gradient noise turbulence engine
// Table loads and noise evaluation behind queue-style request/response ports.
// ----------------------------------------------------------------------------
// Usage: push requests while full is low. Mode 0 and 1 requests load one
// gradient or permutation entry and give no response; mode 2 evaluates the
// turbulence sum of a Q16.16 point and gives one response, popped while
// empty is low. A four-entry request queue sits in front of a sequencer
// that works one request at a time.
// A request pushed into an empty queue is offered to the sequencer in the
// cycle after the push. A noise request passes, per octave, two fade steps,
// then for each of eight corners a permutation read, gradient address,
// gradient read, dot product and sum through the table read ports, then
// three blend steps and one accumulate step. The sequencer takes no new
// request until a noise request is done; loads go at one per cycle while it
// is idle. Reset clears the queue, the sequencer and the response valid flag;
// table contents are undefined until loaded. While pop stays low the finished
// response holds, the sequencer goes on and waits at the end of the next
// noise request, and the request queue keeps filling until full.
// ----------------------------------------------------------------------------
module gradient_noise_turbulence
   import gnt_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
   parameter int MAX_OCTAVES   = MAX_OCTAVES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [1:0]  req_mode,
   input  wire logic [1:0]  req_table_select,
   input  wire logic [7:0]  req_table_index,
   input  wire logic signed [15:0] req_grad_x,
   input  wire logic signed [15:0] req_grad_y,
   input  wire logic signed [15:0] req_grad_z,
   input  wire logic [7:0]  req_perm_value,
   input  wire logic signed [31:0] req_point_x,
   input  wire logic signed [31:0] req_point_y,
   input  wire logic signed [31:0] req_point_z,
   input  wire logic [3:0]  req_octaves,
   output logic             empty,
   input  wire logic        pop,
   output logic [23:0]      rsp_noise_value
);
   logic    job_valid, job_take, res_valid;
   job_type job;

   gnt_front #(.MAX_OCTAVES(MAX_OCTAVES), .DEPTH(4)) u_front (
      .clock, .reset, .push, .full,
      .mode(req_mode), .table_select(req_table_select),
      .table_index(req_table_index),
      .grad_x(req_grad_x), .grad_y(req_grad_y), .grad_z(req_grad_z),
      .perm_value(req_perm_value),
      .point_x(req_point_x), .point_y(req_point_y), .point_z(req_point_z),
      .octaves(req_octaves),
      .job_valid, .job_take, .job
   );

   gnt_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .MAX_OCTAVES(MAX_OCTAVES)) u_back (
      .clock, .reset, .job_valid, .job_take, .job,
      .res_valid, .res_take(pop), .res_value(rsp_noise_value)
   );

   assign empty = !res_valid;

endmodule : gradient_noise_turbulence
`default_nettype wire

@@ design/gnt_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gnt_front: request intake and classification
// Drops unknown modes, clamps octave counts and queues jobs for the back end.
// ----------------------------------------------------------------------------
module gnt_front
   import gnt_pkg::*;
#(
   parameter int MAX_OCTAVES = MAX_OCTAVES_DEF,
   parameter int DEPTH       = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [1:0]  mode,
   input  wire logic [1:0]  table_select,
   input  wire logic [7:0]  table_index,
   input  wire logic [15:0] grad_x,
   input  wire logic [15:0] grad_y,
   input  wire logic [15:0] grad_z,
   input  wire logic [7:0]  perm_value,
   input  wire logic [31:0] point_x,
   input  wire logic [31:0] point_y,
   input  wire logic [31:0] point_z,
   input  wire logic [3:0]  octaves,
   output logic             job_valid,
   input  wire logic        job_take,
   output job_type          job
);
   localparam int AW = $clog2(DEPTH);

   job_type        q_ff [DEPTH];
   logic [AW-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]    cnt_ff, cnt_in;
   job_type        cls;
   logic           wr_en, rd_en;

   // Classify the incoming request.
   always_comb begin
      cls.mode = mode_type'(mode);
      cls.sel = sel_type'(table_select);
      cls.index = table_index;
      cls.gx = grad_x;
      cls.gy = grad_y;
      cls.gz = grad_z;
      cls.perm = perm_value;
      cls.px = point_x;
      cls.py = point_y;
      cls.pz = point_z;
      if ({1'b0, octaves} > 5'(MAX_OCTAVES)) cls.octaves = 5'(MAX_OCTAVES);
      else cls.octaves = {1'b0, octaves};
   end

   assign full      = (cnt_ff == (AW+1)'(DEPTH));
   assign wr_en     = push && !full && (mode_type'(mode) != MODE_NONE);
   assign job_valid = (cnt_ff != '0);
   assign rd_en     = job_valid && job_take;
   assign job       = q_ff[rd_ff];

   // Advance pointers and count.
   always_comb begin
      wr_in  = wr_en ? AW'((32'(wr_ff) + 1) % DEPTH) : wr_ff;
      rd_in  = rd_en ? AW'((32'(rd_ff) + 1) % DEPTH) : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(wr_en) - (AW+1)'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) q_ff[wr_ff] <= cls;
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (AW+1)'(DEPTH)) else $error("queue count overflow");
   a_no_full_write: assert property (@(posedge clock) disable iff (reset)
      full |=> cnt_ff == $past(cnt_ff) - (AW+1)'($past(rd_en)))
      else $error("write into full queue");
   a_oct_clamp: assert property (@(posedge clock) disable iff (reset)
      job_valid |-> job.octaves <= 5'(MAX_OCTAVES)) else $error("octave clamp");

endmodule : gnt_front
`default_nettype wire

@@ design/gnt_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gnt_back: table stores and octave sequencer
// Writes table entries; for noise jobs walks octaves through a staged
// sequence of table reads, fades, dot products and blends.
// ----------------------------------------------------------------------------
module gnt_back
   import gnt_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
   parameter int MAX_OCTAVES   = MAX_OCTAVES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        job_valid,
   output logic             job_take,
   input  wire job_type     job,
   output logic             res_valid,
   input  wire logic        res_take,
   output logic [23:0]      res_value
);
   localparam int TW = $clog2(TABLE_ENTRIES);
   localparam int AW = 16 + MAX_OCTAVES + 40;

   logic [47:0] grad_mem [TABLE_ENTRIES];
   logic [7:0]  permx_mem [TABLE_ENTRIES];
   logic [7:0]  permy_mem [TABLE_ENTRIES];
   logic [7:0]  permz_mem [TABLE_ENTRIES];

   bst_type st_ff, st_in;
   logic [31:0] px_ff, py_ff, pz_ff;
   logic [4:0]  left_ff, oct_ff;
   logic [2:0]  corner_ff;
   logic [AW-1:0] acc_ff;
   logic [23:0] res_ff;
   logic        res_valid_ff;
   logic        done_go;
   logic [7:0]  pxr_ff, pyr_ff, pzr_ff;
   logic [TW-1:0] gaddr_ff;
   logic [47:0] g_ff;
   logic [16:0] fx, fy, fz;
   logic [16:0] u2_ff [3];
   logic [16:0] u3_ff [3];
   logic [33:0] h_ff [3];
   logic [16:0] w_ff [3];
   logic signed [33:0] m_ff [3];
   logic signed [40:0] d_ff [8];
   logic signed [40:0] bx_ff [4];
   logic signed [40:0] by_ff [2];
   logic signed [40:0] bz_ff;
   logic [7:0]  cx, cy, cz;

   assign fx = {1'b0, px_ff[15:0]};
   assign fy = {1'b0, py_ff[15:0]};
   assign fz = {1'b0, pz_ff[15:0]};
   assign cx = px_ff[23:16] + 8'(corner_ff[2]);
   assign cy = py_ff[23:16] + 8'(corner_ff[1]);
   assign cz = pz_ff[23:16] + 8'(corner_ff[0]);

   // Finish a noise job once the response register is free or being popped.
   assign done_go   = (st_ff == ST_DONE) && (!res_valid_ff || res_take);
   assign job_take  = (st_ff == ST_IDLE) && job_valid;
   assign res_valid = res_valid_ff;
   assign res_value = res_ff;

   function automatic logic signed [40:0] blend(input logic signed [40:0] a,
                                               input logic signed [40:0] b,
                                               input logic [16:0] w);
      logic signed [63:0] s;
      s = 64'(a) * 64'(signed'({1'b0, 17'h10000 - w})) + 64'(b) * 64'(signed'({1'b0, w}));
      blend = 41'(fshr16(s));
   endfunction

   // Table writes.
   always_ff @(posedge clock) begin
      if (job_take && job.mode == MODE_LOAD_GRAD)
         grad_mem[TW'(job.index)] <= {job.gx, job.gy, job.gz};
      if (job_take && job.mode == MODE_LOAD_PERM && job.sel == SEL_X)
         permx_mem[TW'(job.index)] <= job.perm;
      if (job_take && job.mode == MODE_LOAD_PERM && job.sel == SEL_Y)
         permy_mem[TW'(job.index)] <= job.perm;
      if (job_take && job.mode == MODE_LOAD_PERM && job.sel == SEL_Z)
         permz_mem[TW'(job.index)] <= job.perm;
   end

   // Registered table reads.
   always_ff @(posedge clock) begin
      pxr_ff <= permx_mem[TW'(cx)];
      pyr_ff <= permy_mem[TW'(cy)];
      pzr_ff <= permz_mem[TW'(cz)];
      g_ff   <= grad_mem[gaddr_ff];
   end

   // Next state.
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE:  if (job_take && job.mode == MODE_NOISE)
                      st_in = (job.octaves == '0) ? ST_DONE : ST_FADE1;
         ST_FADE1: st_in = ST_FADE2;
         ST_FADE2: st_in = ST_PERM;
         ST_PERM:  st_in = ST_GADDR;
         ST_GADDR: st_in = ST_GRAD;
         ST_GRAD:  st_in = ST_DOT;
         ST_DOT:   st_in = ST_SUM;
         ST_SUM:   st_in = (corner_ff == 3'd7) ? ST_BX : ST_PERM;
         ST_BX:    st_in = ST_BY;
         ST_BY:    st_in = ST_BZ;
         ST_BZ:    st_in = ST_ACC;
         ST_ACC:   st_in = (left_ff == 5'd1) ? ST_DONE : ST_FADE1;
         ST_DONE:  st_in = done_go ? ST_IDLE : ST_DONE;
         default:  st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= ST_IDLE;
      else       st_ff <= st_in;
   end

   // Hold the response until popped; load a new one when a job finishes.
   always_ff @(posedge clock) begin
      if (reset)         res_valid_ff <= 1'b0;
      else if (done_go)  res_valid_ff <= 1'b1;
      else if (res_take) res_valid_ff <= 1'b0;
   end

   // Datapath per state.
   always_ff @(posedge clock) begin
      if (!reset) begin
         case (st_ff)
            ST_IDLE: begin
               if (job_take) begin
                  px_ff <= job.px;
                  py_ff <= job.py;
                  pz_ff <= job.pz;
                  left_ff <= job.octaves;
                  oct_ff <= '0;
                  acc_ff <= '0;
                  corner_ff <= '0;
               end
            end
            ST_FADE1: begin
               u2_ff[0] <= 17'((34'(fx) * 34'(fx)) >> 16);
               u2_ff[1] <= 17'((34'(fy) * 34'(fy)) >> 16);
               u2_ff[2] <= 17'((34'(fz) * 34'(fz)) >> 16);
               h_ff[0] <= 34'((36'd6 * 36'(fx) * 36'(fx) + (36'd10 << 32)
                          - ((36'd15 * 36'(fx)) << 16)) >> 16);
               h_ff[1] <= 34'((36'd6 * 36'(fy) * 36'(fy) + (36'd10 << 32)
                          - ((36'd15 * 36'(fy)) << 16)) >> 16);
               h_ff[2] <= 34'((36'd6 * 36'(fz) * 36'(fz) + (36'd10 << 32)
                          - ((36'd15 * 36'(fz)) << 16)) >> 16);
            end
            ST_FADE2: begin
               u3_ff[0] <= 17'((34'(u2_ff[0]) * 34'(fx)) >> 16);
               u3_ff[1] <= 17'((34'(u2_ff[1]) * 34'(fy)) >> 16);
               u3_ff[2] <= 17'((34'(u2_ff[2]) * 34'(fz)) >> 16);
            end
            ST_PERM: begin
               if (corner_ff == 3'd0) begin
                  for (int i = 0; i < 3; i++) begin
                     if (((51'(u3_ff[i]) * 51'(h_ff[i])) >> 16) > 51'd65536)
                        w_ff[i] <= 17'h10000;
                     else
                        w_ff[i] <= 17'((51'(u3_ff[i]) * 51'(h_ff[i])) >> 16);
                  end
               end
            end
            ST_GADDR: gaddr_ff <= TW'(pxr_ff ^ pyr_ff ^ pzr_ff);
            ST_DOT: begin
               m_ff[0] <= 34'(signed'(g_ff[47:32])) *
                          34'(signed'({1'b0, fx} - (corner_ff[2] ? 18'h10000 : 18'h0)));
               m_ff[1] <= 34'(signed'(g_ff[31:16])) *
                          34'(signed'({1'b0, fy} - (corner_ff[1] ? 18'h10000 : 18'h0)));
               m_ff[2] <= 34'(signed'(g_ff[15:0])) *
                          34'(signed'({1'b0, fz} - (corner_ff[0] ? 18'h10000 : 18'h0)));
            end
            ST_SUM: begin
               d_ff[corner_ff] <= 41'(m_ff[0]) + 41'(m_ff[1]) + 41'(m_ff[2]);
               corner_ff <= corner_ff + 3'd1;
            end
            ST_BX: begin
               bx_ff[0] <= blend(d_ff[0], d_ff[4], w_ff[0]);
               bx_ff[1] <= blend(d_ff[2], d_ff[6], w_ff[0]);
               bx_ff[2] <= blend(d_ff[1], d_ff[5], w_ff[0]);
               bx_ff[3] <= blend(d_ff[3], d_ff[7], w_ff[0]);
            end
            ST_BY: begin
               by_ff[0] <= blend(bx_ff[0], bx_ff[1], w_ff[1]);
               by_ff[1] <= blend(bx_ff[2], bx_ff[3], w_ff[1]);
            end
            ST_BZ: bz_ff <= blend(by_ff[0], by_ff[1], w_ff[2]);
            ST_ACC: begin
               acc_ff <= acc_ff + (AW'(bz_ff < 0 ? -bz_ff : bz_ff)
                         << (MAX_OCTAVES - 1 - int'(oct_ff)));
               oct_ff <= oct_ff + 5'd1;
               left_ff <= left_ff - 5'd1;
               px_ff <= px_ff << 1;
               py_ff <= py_ff << 1;
               pz_ff <= pz_ff << 1;
            end
            ST_DONE: begin
               if (done_go) begin
                  if ((acc_ff >> (14 + MAX_OCTAVES - 1)) > AW'(24'hFFFFFF))
                     res_ff <= 24'hFFFFFF;
                  else
                     res_ff <= 24'(acc_ff >> (14 + MAX_OCTAVES - 1));
               end
            end
            default: ;
         endcase
      end
   end

   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      job_take |-> st_ff == ST_IDLE) else $error("take while busy");
   a_done_valid: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_DONE |=> res_valid_ff) else $error("result lost");
   a_corner: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_BX |-> corner_ff == 3'd0) else $error("corner count");

endmodule : gnt_back
`default_nettype wire
